>>> rtl/pdc_pkg.sv
package pdc_pkg;

	localparam int GAIN_FRAC_BITS = 8;
	localparam int ERR_STORE_W    = 16;
	localparam int GAIN_W         = 16;
	localparam int POS_W          = 32;
	localparam int DUTY_W         = 8;
	localparam int APB_ADDR_W     = 5;
	localparam int APB_DATA_W     = 32;
	localparam int REG_IDX_W      = 3;

	localparam int MUL_A_W  = POS_W + 2;
	localparam int MUL_B_W  = GAIN_W + 1;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int ACC_W    = PROD_W + 1;
	localparam int BOUND_W  = GAIN_W + GAIN_FRAC_BITS;
	localparam int QUO_W    = 7;
	localparam int DIV_W    = BOUND_W + QUO_W - 1;
	localparam int NUM_W    = BOUND_W + QUO_W;
	localparam int CNT_W    = 3;

	localparam logic [MUL_B_W-1:0] DUTY_SCALE = MUL_B_W'(100);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_GAIN_P      = 3'd0,
		REG_GAIN_I      = 3'd1,
		REG_GAIN_D      = 3'd2,
		REG_CLAMP_LIMIT = 3'd3,
		REG_TARGET_POS  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0]       gain_p;
		logic [GAIN_W-1:0]       gain_i;
		logic [GAIN_W-1:0]       gain_d;
		logic [GAIN_W-1:0]       clamp_limit;
		logic signed [POS_W-1:0] target_position;
	} cfg_t;

	localparam logic [GAIN_W-1:0] RST_GAIN_P      = 16'd384;
	localparam logic [GAIN_W-1:0] RST_GAIN_I      = 16'd51;
	localparam logic [GAIN_W-1:0] RST_GAIN_D      = 16'd26;
	localparam logic [GAIN_W-1:0] RST_CLAMP_LIMIT = 16'd510;
	localparam logic [POS_W-1:0]  RST_TARGET_POS  = 32'd102000;

endpackage

>>> rtl/pid_position_duty_core.sv
// Position PID controller with output clamp. Each word on the input stream is a signed
// 32-bit encoder count; the block forms error = target - count, sums P, D and I terms
// with unsigned Q8.8 gains, clamps the sum to +/- clamp_limit and returns one signed
// duty in percent (-100..100, truncated toward zero; 0 when clamp_limit is 0). All
// products go through one shared 34x17 multiplier and the scaling through a restoring
// divider yielding one quotient bit a cycle. s_tready is low from acceptance until the
// result is loaded into the output register, and a new word is taken in the cycle after
// that load. Registers: gain_p at 0x00, gain_i at 0x04, gain_d at 0x08, clamp_limit at
// 0x0c, target_position at 0x10; write them only while no item is in flight.
module pid_position_duty_core import pdc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [POS_W-1:0]      s_tdata,  // [31:0] encoder_count
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [DUTY_W-1:0]     m_tdata,  // [7:0] duty_percent
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_P     = 10'b00_0000_0010,
		ST_D     = 10'b00_0000_0100,
		ST_I     = 10'b00_0000_1000,
		ST_SUM   = 10'b00_0001_0000,
		ST_CLAMP = 10'b00_0010_0000,
		ST_SCALE = 10'b00_0100_0000,
		ST_LOAD  = 10'b00_1000_0000,
		ST_DIV   = 10'b01_0000_0000,
		ST_OUT   = 10'b10_0000_0000
	} state_t;

	cfg_t cfg;

	state_t                        st_q;
	logic signed [POS_W-1:0]       err_q;
	logic signed [POS_W:0]         diff_q;
	logic signed [ERR_STORE_W-1:0] last_err_q;
	logic signed [ERR_STORE_W-1:0] err_sum_q;
	logic signed [PROD_W-1:0]      prod_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic [BOUND_W-1:0]            mag_q;
	logic                          neg_q;
	logic                          zero_q;
	logic [NUM_W-1:0]              rem_q;
	logic [DIV_W-1:0]              div_q;
	logic [QUO_W-1:0]              quo_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          m_tvalid_q;
	logic [DUTY_W-1:0]             m_tdata_q;

	logic signed [MUL_A_W-1:0] op_a;
	logic signed [MUL_B_W-1:0] op_b;
	logic signed [PROD_W-1:0]  prod;
	logic [BOUND_W-1:0]        bound;
	logic signed [ACC_W-1:0]   bound_pos;
	logic signed [ACC_W-1:0]   bound_neg;
	logic signed [ACC_W-1:0]   acc_abs;
	logic [NUM_W-1:0]          div_ext;
	logic [DUTY_W-1:0]         quo_ext;
	logic                      in_acc;

	pdc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign s_tready = (st_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign in_acc   = s_tvalid & s_tready;

	// shared multiplier operand select
	always_comb begin
		unique case (st_q)
			ST_P: begin
				op_a = MUL_A_W'(err_q);
				op_b = $signed({1'b0, cfg.gain_p});
			end
			ST_D: begin
				op_a = MUL_A_W'(diff_q);
				op_b = $signed({1'b0, cfg.gain_d});
			end
			ST_I: begin
				op_a = MUL_A_W'(err_sum_q);
				op_b = $signed({1'b0, cfg.gain_i});
			end
			ST_SCALE: begin
				op_a = $signed({{(MUL_A_W-BOUND_W){1'b0}}, mag_q});
				op_b = $signed(DUTY_SCALE);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod      = op_a * op_b;
	assign bound     = {cfg.clamp_limit, {GAIN_FRAC_BITS{1'b0}}};
	assign bound_pos = $signed({{(ACC_W-BOUND_W){1'b0}}, bound});
	assign bound_neg = -bound_pos;
	assign acc_abs   = acc_q[ACC_W-1] ? -acc_q : acc_q;
	assign div_ext   = NUM_W'(div_q);
	assign quo_ext   = DUTY_W'(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			last_err_q <= '0;
			err_sum_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && st_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						st_q <= ST_P;
					end
				end
				ST_P: begin
					last_err_q <= err_q[ERR_STORE_W-1:0];
					err_sum_q  <= err_sum_q + err_q[ERR_STORE_W-1:0];
					st_q       <= ST_D;
				end
				ST_D:     st_q <= ST_I;
				ST_I:     st_q <= ST_SUM;
				ST_SUM:   st_q <= ST_CLAMP;
				ST_CLAMP: st_q <= ST_SCALE;
				ST_SCALE: st_q <= ST_LOAD;
				ST_LOAD:  st_q <= ST_DIV;
				ST_DIV: begin
					if (cnt_q == '0) begin
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						st_q       <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (in_acc) begin
					err_q <= cfg.target_position - $signed(s_tdata);
				end
			end
			ST_P: begin
				diff_q <= (POS_W+1)'(err_q) - (POS_W+1)'(last_err_q);
				prod_q <= prod;
			end
			ST_D: begin
				acc_q  <= ACC_W'(prod_q);
				prod_q <= prod;
			end
			ST_I: begin
				acc_q  <= acc_q + ACC_W'(prod_q);
				prod_q <= prod;
			end
			ST_SUM: begin
				acc_q <= acc_q + ACC_W'(prod_q);
			end
			ST_CLAMP: begin
				neg_q  <= acc_q[ACC_W-1];
				zero_q <= (cfg.clamp_limit == '0);
				if (acc_q > bound_pos || acc_q < bound_neg) begin
					mag_q <= bound;
				end else begin
					mag_q <= acc_abs[BOUND_W-1:0];
				end
			end
			ST_SCALE: begin
				prod_q <= prod;
			end
			ST_LOAD: begin
				rem_q <= prod_q[NUM_W-1:0];
				div_q <= {bound, {(QUO_W-1){1'b0}}};
				quo_q <= '0;
				cnt_q <= CNT_W'(QUO_W - 1);
			end
			ST_DIV: begin
				if (rem_q >= div_ext) begin
					rem_q <= rem_q - div_ext;
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
				div_q <= div_q >> 1;
				cnt_q <= cnt_q - 1'b1;
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					if (zero_q) begin
						m_tdata_q <= '0;
					end else if (neg_q) begin
						m_tdata_q <= -quo_ext;
					end else begin
						m_tdata_q <= quo_ext;
					end
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken again while busy");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata) <= 8'sd100 && $signed(m_tdata) >= -8'sd100))
		else $error("duty out of range");

	a_load_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(st_q == ST_OUT))
		else $error("result word loaded outside output state");

	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT && !zero_q) |-> quo_q <= QUO_W'(100))
		else $error("scaled quotient above full scale");
`endif

endmodule

>>> rtl/pdc_regs.sv
module pdc_regs import pdc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p          <= RST_GAIN_P;
			cfg_q.gain_i          <= RST_GAIN_I;
			cfg_q.gain_d          <= RST_GAIN_D;
			cfg_q.clamp_limit     <= RST_CLAMP_LIMIT;
			cfg_q.target_position <= RST_TARGET_POS;
		end else if (wr_en) begin
			unique case (idx)
				REG_GAIN_P:      cfg_q.gain_p          <= pwdata[GAIN_W-1:0];
				REG_GAIN_I:      cfg_q.gain_i          <= pwdata[GAIN_W-1:0];
				REG_GAIN_D:      cfg_q.gain_d          <= pwdata[GAIN_W-1:0];
				REG_CLAMP_LIMIT: cfg_q.clamp_limit     <= pwdata[GAIN_W-1:0];
				REG_TARGET_POS:  cfg_q.target_position <= pwdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_GAIN_P:      prdata = APB_DATA_W'(cfg_q.gain_p);
			REG_GAIN_I:      prdata = APB_DATA_W'(cfg_q.gain_i);
			REG_GAIN_D:      prdata = APB_DATA_W'(cfg_q.gain_d);
			REG_CLAMP_LIMIT: prdata = APB_DATA_W'(cfg_q.clamp_limit);
			REG_TARGET_POS:  prdata = APB_DATA_W'(cfg_q.target_position);
			default:         prdata = '0;
		endcase
	end

endmodule
